// ----- rtl/pms_pkg.sv -----
// Package for the pyramid match similarity block: payload structs and constants.
// No dependencies.
package pms_pkg;

    typedef struct packed {
        logic [3:0]  level;
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] similarity_q16;
        logic               saturated;
        logic               divide_by_zero;
    } t_out_item;

    localparam int unsigned ACC_BITS = 32;
    localparam int unsigned RES_BITS = 48;
    localparam logic [4:0]  LEVELS_RESET = 5'd8;
    localparam logic        REG_LEVELS = 1'b0;
    localparam logic        REG_NORMALIZE = 1'b1;

endpackage

// ----- rtl/pms_queue.sv -----
// Short queue between the intake stage and the accumulate/finish engine.
// Depends on pms_pkg.
module pms_queue
    import pms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_in_item o_item
);

    t_in_item   r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_pop};
        end
    end

endmodule

// ----- rtl/pms_engine.sv -----
// Accumulate engine: per-level min sums, self sums, final weighted sum,
// isqrt and divide as multi-cycle iterative steps. Depends on pms_pkg.
module pms_engine
    import pms_pkg::*;
#(
    parameter int MAX_LEVELS = 16,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [4:0] i_levels,
    input  logic      i_normalize,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [2:0] S_ACC = 3'd0, S_SUM = 3'd1, S_SQRT = 3'd2,
                           S_DIV = 3'd3, S_OUT = 3'd4;
    localparam logic [ACC_BITS:0] ACC_MAX = {1'b0, {ACC_BITS{1'b1}}};

    logic [2:0]          r_state;
    logic [ACC_BITS-1:0] r_lvl [MAX_LEVELS];
    logic [ACC_BITS-1:0] r_sa, r_sb;
    logic                r_ovf;
    logic [5:0]          r_idx;
    logic [5:0]          r_lim;
    logic [63:0]         r_sum;
    logic [63:0]         r_v, r_res, r_bit;
    logic [63:0]         r_rem, r_quo;
    logic [6:0]          r_k;
    t_out_item           r_out;

    logic [COUNT_BITS-1:0] w_ca, w_cb, w_mn;
    logic [5:0]            w_lim;
    logic [ACC_BITS:0]     w_lsum, w_asum, w_bsum;
    logic [LW-1:0]         w_li;
    logic [ACC_BITS+63:0]  w_sc;
    logic [63:0]           w_term;
    logic [64:0]           w_rbit, w_rsh;
    logic [64:0]           w_trem;

    assign w_ca  = COUNT_BITS'(i_item.count_a);
    assign w_cb  = COUNT_BITS'(i_item.count_b);
    assign w_mn  = (w_ca < w_cb) ? w_ca : w_cb;
    assign w_lim = ({1'b0, i_levels} < 6'(MAX_LEVELS)) ? {1'b0, i_levels}
                                                       : 6'(MAX_LEVELS);
    assign w_li  = LW'(i_item.level);
    assign w_lsum = {1'b0, r_lvl[w_li]} + (ACC_BITS+1)'(w_mn);
    assign w_asum = {1'b0, r_sa} + (ACC_BITS+1)'(w_ca);
    assign w_bsum = {1'b0, r_sb} + (ACC_BITS+1)'(w_cb);

    // term i: m_i * 2^F >> (i+1), except the top level which shifts by i
    assign w_sc   = (ACC_BITS+64)'(r_lvl[r_idx[LW-1:0]]) << FRAC_BITS;
    assign w_term = 64'((r_idx + 6'd1 < r_lim) ? (w_sc >> (r_idx + 6'd1))
                                               : (w_sc >> r_idx));
    assign w_rbit = {1'b0, r_res} + {1'b0, r_bit};
    assign w_rsh  = {1'b0, r_res >> 1};
    assign w_trem = {r_rem, r_sum[63]};

    assign o_ready = (r_state == S_ACC);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_sa    <= '0;
            r_sb    <= '0;
            r_ovf   <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) r_lvl[i] <= '0;
        end else begin
            unique case (r_state)
                S_ACC: begin
                    if (i_valid) begin
                        if ({2'b0, i_item.level} < w_lim) begin
                            r_lvl[w_li] <= (w_lsum > ACC_MAX) ? ACC_MAX[ACC_BITS-1:0]
                                                              : w_lsum[ACC_BITS-1:0];
                            if (i_item.level == 4'd0) begin
                                r_sa <= (w_asum > ACC_MAX) ? ACC_MAX[ACC_BITS-1:0]
                                                           : w_asum[ACC_BITS-1:0];
                                r_sb <= (w_bsum > ACC_MAX) ? ACC_MAX[ACC_BITS-1:0]
                                                           : w_bsum[ACC_BITS-1:0];
                            end
                            if (w_lsum > ACC_MAX || (i_item.level == 4'd0 &&
                                (w_asum > ACC_MAX || w_bsum > ACC_MAX))) begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (i_item.last) begin
                            r_state <= S_SUM;
                            r_idx   <= '0;
                            r_lim   <= w_lim;
                            r_sum   <= '0;
                        end
                    end
                end
                S_SUM: begin
                    if (r_idx < r_lim) begin
                        r_sum <= r_sum + w_term;
                        r_idx <= r_idx + 6'd1;
                    end else if (i_normalize) begin
                        r_v     <= 64'(r_sa) * 64'(r_sb);
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_OUT;
                        r_out.divide_by_zero <= 1'b0;
                        r_out.saturated <= r_ovf || (r_sum > 64'h7FFF_FFFF_FFFF);
                        r_out.similarity_q16 <= (r_sum > 64'h7FFF_FFFF_FFFF)
                            ? 48'h7FFF_FFFF_FFFF : r_sum[47:0];
                    end
                end
                S_SQRT: begin
                    // one radix-4 digit per cycle
                    if (r_bit != 64'd0) begin
                        if ({1'b0, r_v} >= w_rbit) begin
                            r_v   <= r_v - w_rbit[63:0];
                            r_res <= w_rsh[63:0] + r_bit;
                        end else begin
                            r_res <= w_rsh[63:0];
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_k     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (r_res == 64'd0) begin
                        r_state <= S_OUT;
                        r_out.divide_by_zero <= 1'b1;
                        r_out.saturated <= r_ovf;
                        r_out.similarity_q16 <= '0;
                    end else if (r_k != 7'd64) begin
                        if (w_trem >= {1'b0, r_res}) begin
                            r_rem <= 64'(w_trem - {1'b0, r_res});
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= w_trem[63:0];
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_sum <= r_sum << 1;
                        r_k   <= r_k + 7'd1;
                    end else begin
                        r_state <= S_OUT;
                        r_out.divide_by_zero <= 1'b0;
                        r_out.saturated <= r_ovf || (r_quo > 64'h7FFF_FFFF_FFFF);
                        r_out.similarity_q16 <= (r_quo > 64'h7FFF_FFFF_FFFF)
                            ? 48'h7FFF_FFFF_FFFF : r_quo[47:0];
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_ACC;
                        r_sa    <= '0;
                        r_sb    <= '0;
                        r_ovf   <= 1'b0;
                        for (int i = 0; i < MAX_LEVELS; i++) r_lvl[i] <= '0;
                    end
                end
                default: r_state <= S_ACC;
            endcase
        end
    end

endmodule

// ----- rtl/pyramid_match_similarity.sv -----
// Top level: APB register file, intake queue and accumulate engine.
// Depends on pms_pkg, pms_queue, pms_engine.
// Throughput: one bin pair per cycle while accumulating (4-entry queue in front).
// After the last pair: the weighted level sum, then with normalize an isqrt and
// a divide; one result every such pass, and new pairs wait until it is taken.
// Reset (synchronous): accumulators cleared, levels_in_use = 8, normalize = 0.
module pyramid_match_similarity
    import pms_pkg::*;
#(
    parameter int MAX_LEVELS = 16,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    logic [4:0] r_levels;
    logic       r_normalize;
    logic       w_qv, w_qr;
    t_in_item   w_qi;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= LEVELS_RESET;
            r_normalize <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_LEVELS)    r_levels    <= pwdata[4:0];
            if (paddr[2] == REG_NORMALIZE) r_normalize <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LEVELS) prdata = {27'b0, r_levels};
        else                        prdata = {31'b0, r_normalize};
    end

    pms_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_item,
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_qi)
    );

    pms_engine #(
        .MAX_LEVELS(MAX_LEVELS), .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)
    ) u_engine (
        .i_clk, .i_rst_n,
        .i_levels(r_levels), .i_normalize(r_normalize),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_qi),
        .o_valid, .i_ready, .o_item
    );

endmodule
